@@ src/pct_pkg.sv @@
// shared constants, types and helpers for the correlation t-value block
package pct_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 16;
   localparam int CNT_W       = COUNT_BITS + 1;
   localparam int SUM_W       = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W        = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int XP_W        = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int W           = 64;
   localparam int PW          = 2 * W;
   localparam int FRAC        = 16;
   localparam int R_W         = FRAC + 1;
   localparam int DF_W        = 16;
   localparam int U_W         = R_W + DF_W;
   localparam int T_W         = 32;
   localparam int ITER_W      = 7;
   localparam int T_SAT_SHIFT = 30;

   localparam logic [R_W-1:0] R_ONE      = R_W'(1) << FRAC;
   localparam logic [T_W-1:0] T_MAX      = 32'h7FFF_FFFF;
   localparam logic [T_W-1:0] T_SENTINEL = 32'hFFF0_BDC0;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FEW     = 2'd1,
      ST_ZVAR    = 2'd2,
      ST_PERFECT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NSXX = 4'd0,
      OP_AXX  = 4'd1,
      OP_NSYY = 4'd2,
      OP_AYY  = 4'd3,
      OP_NSXY = 4'd4,
      OP_SXSY = 4'd5,
      OP_PVAR = 4'd6,
      OP_PCOV = 4'd7,
      OP_RDIV = 4'd8,
      OP_RSQ  = 4'd9,
      OP_UMUL = 4'd10,
      OP_TDIV = 4'd11,
      OP_TSQ  = 4'd12
   } op_type;

   typedef struct packed {
      logic   accumulate;
      logic   clear;
      logic   start;
      logic   run;
      logic   store;
      logic   load_out;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last_iter;
   } sts_type;

   function automatic logic [ITER_W-1:0] op_last(input op_type op);
      logic [ITER_W-1:0] n;
      case (op)
         OP_RDIV:        n = ITER_W'(R_W - 1);
         OP_TDIV:        n = ITER_W'(U_W + T_W - 1);
         OP_RSQ, OP_TSQ: n = ITER_W'(W / 2 - 1);
         default:        n = ITER_W'(W - 1);
      endcase
      return n;
   endfunction

endpackage

@@ src/pearson_correlation_t_value.sv @@
// Pearson correlation with r squared and t value, top level.
// Each non-last pair is a transfer that adds into the count and the sums of x, y,
// x*x, y*y and x*y. A pair flagged last is added too, then the input stalls while one
// shared radix-2 unit evaluates the result: nine 64-bit shift-add multiplies, a 17-step
// divide for r squared, a 65-step divide for t squared and two 32-step square roots. The
// result then sits in an output register until taken while the next data set already
// streams in. Once 65536 pairs are counted further pairs are dropped from the sums.
module pearson_correlation_t_value (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pct_pkg::SAMPLE_BITS-1:0] req_x_sample,
   input  logic signed [pct_pkg::SAMPLE_BITS-1:0] req_y_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pct_pkg::R_W-1:0]                rsp_r_squared,
   output logic [pct_pkg::R_W-1:0]                rsp_r_magnitude,
   output logic                                   rsp_covariance_negative,
   output logic signed [pct_pkg::T_W-1:0]         rsp_t_statistic,
   output logic [pct_pkg::DF_W-1:0]               rsp_degrees_of_freedom,
   output logic [1:0]                             rsp_status
);
   import pct_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pct_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .sts             (sts)
   );

   pct_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_x_sample            (req_x_sample),
      .req_y_sample            (req_y_sample),
      .rsp_r_squared           (rsp_r_squared),
      .rsp_r_magnitude         (rsp_r_magnitude),
      .rsp_covariance_negative (rsp_covariance_negative),
      .rsp_t_statistic         (rsp_t_statistic),
      .rsp_degrees_of_freedom  (rsp_degrees_of_freedom),
      .rsp_status              (rsp_status)
   );

endmodule

@@ src/pct_ctrl.sv @@
// controller state machine: handshakes and operation sequencing
module pct_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_sample,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pct_pkg::cmd_type cmd,
   input  pct_pkg::sts_type sts
);
   import pct_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_RUN    = 5'b00100,
      S_STORE  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.accumulate = accept;
            if (accept && req_last_sample) begin
               state_in = S_START;
               op_in    = OP_NSXX;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_RUN;
         end
         S_RUN: begin
            cmd.run = 1'b1;
            if (sts.last_iter) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == OP_TSQ) begin
               state_in = S_FINISH;
            end else begin
               op_in    = op_type'(op_ff + 4'd1);
               state_in = S_START;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_NSXX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten");
   a_iter_in_run: assert property (@(posedge clock) disable iff (reset)
      sts.last_iter |-> (state_ff == S_RUN))
      else $error("iteration end outside run");
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_sample) |=>
      (state_ff == S_START && op_ff == OP_NSXX))
      else $error("last transfer did not start evaluation");
   a_seq_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE && op_ff == OP_TSQ) |=> (state_ff == S_FINISH))
      else $error("sequence end missed");
`endif

endmodule

@@ src/pct_dp.sv @@
// datapath: accumulators, shared iterative multiply/divide/root unit, result register
module pct_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pct_pkg::cmd_type                       cmd,
   output pct_pkg::sts_type                       sts,
   input  logic signed [pct_pkg::SAMPLE_BITS-1:0] req_x_sample,
   input  logic signed [pct_pkg::SAMPLE_BITS-1:0] req_y_sample,
   output logic [pct_pkg::R_W-1:0]                rsp_r_squared,
   output logic [pct_pkg::R_W-1:0]                rsp_r_magnitude,
   output logic                                   rsp_covariance_negative,
   output logic signed [pct_pkg::T_W-1:0]         rsp_t_statistic,
   output logic [pct_pkg::DF_W-1:0]               rsp_degrees_of_freedom,
   output logic [1:0]                             rsp_status
);
   import pct_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SQ_W-1:0]  sxx2_ff, sxx2_in, syy2_ff, syy2_in;
   logic [XP_W-1:0]  sxp_ff, sxp_in;
   logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

   logic [W-1:0]     tmp_ff, sxx_ff, syy_ff, sxy_ff, q_ff;
   logic [PW-1:0]    pvar_ff, pcov_ff;
   logic [R_W-1:0]   r2_ff, rm_ff;
   logic [U_W-1:0]   u_ff;
   logic [T_W:0]     ts_ff;

   logic [PW-1:0]     acc_ff, acc_in, a_ff, a_in;
   logic [W-1:0]      b_ff, b_in;
   logic [ITER_W-1:0] it_ff, it_in;

   logic [W-1:0]   n64, sx64, sy64, ax, ay, sx2_64, sy2_64, sxp64, axy, mul_a, mul_b;
   logic [DF_W-1:0] df;
   logic           few, zvar;
   logic [R_W-1:0] dden;
   logic [PW-1:0]  divisor;
   logic [PW:0]    trial;
   logic [W-1:0]   sq_t;
   logic [W-1:0]   sq_bit;

   logic [R_W-1:0]  r2_out_ff, rm_out_ff;
   logic            neg_out_ff;
   logic [T_W-1:0]  t_out_ff, t_val;
   logic [DF_W-1:0] df_out_ff;
   status_type      st_out_ff, st_val;

   // accumulation
   assign xx = req_x_sample * req_x_sample;
   assign yy = req_y_sample * req_y_sample;
   assign xy = req_x_sample * req_y_sample;

   always_comb begin
      cnt_in  = cnt_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sxx2_in = sxx2_ff;
      syy2_in = syy2_ff;
      sxp_in  = sxp_ff;
      if (cmd.clear) begin
         cnt_in  = '0;
         sx_in   = '0;
         sy_in   = '0;
         sxx2_in = '0;
         syy2_in = '0;
         sxp_in  = '0;
      end else if (cmd.accumulate && !cnt_ff[COUNT_BITS]) begin
         cnt_in  = cnt_ff + CNT_W'(1);
         sx_in   = sx_ff + SUM_W'(req_x_sample);
         sy_in   = sy_ff + SUM_W'(req_y_sample);
         sxx2_in = sxx2_ff + SQ_W'($unsigned(xx));
         syy2_in = syy2_ff + SQ_W'($unsigned(yy));
         sxp_in  = sxp_ff + XP_W'(xy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         sxx2_ff <= '0;
         syy2_ff <= '0;
         sxp_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sxx2_ff <= sxx2_in;
         syy2_ff <= syy2_in;
         sxp_ff  <= sxp_in;
      end
   end

   // operand forms
   assign n64    = W'(cnt_ff);
   assign sx64   = W'($signed(sx_ff));
   assign sy64   = W'($signed(sy_ff));
   assign ax     = sx64[W-1] ? (W'(0) - sx64) : sx64;
   assign ay     = sy64[W-1] ? (W'(0) - sy64) : sy64;
   assign sx2_64 = W'(sxx2_ff);
   assign sy2_64 = W'(syy2_ff);
   assign sxp64  = W'($signed(sxp_ff));
   assign axy    = sxy_ff[W-1] ? (W'(0) - sxy_ff) : sxy_ff;
   assign few    = (cnt_ff < CNT_W'(3));
   assign df     = few ? '0 : DF_W'(cnt_ff - CNT_W'(2));
   assign zvar   = (sxx_ff == '0) || (syy_ff == '0);
   assign dden   = R_ONE - r2_ff;
   assign sq_bit = W'(1) << (W - 2);

   always_comb begin
      case (cmd.op)
         OP_NSXX: begin mul_a = n64;         mul_b = sx2_64; end
         OP_AXX:  begin mul_a = ax;          mul_b = ax;     end
         OP_NSYY: begin mul_a = n64;         mul_b = sy2_64; end
         OP_AYY:  begin mul_a = ay;          mul_b = ay;     end
         OP_NSXY: begin mul_a = sxp64;       mul_b = n64;    end
         OP_SXSY: begin mul_a = sx64;        mul_b = sy64;   end
         OP_PVAR: begin mul_a = sxx_ff;      mul_b = syy_ff; end
         OP_PCOV: begin mul_a = axy;         mul_b = axy;    end
         OP_UMUL: begin mul_a = W'(r2_ff);   mul_b = W'(df); end
         default: begin mul_a = '0;          mul_b = '0;     end
      endcase
   end

   // shared iterative unit
   assign divisor = (cmd.op == OP_RDIV) ? pvar_ff : PW'(dden);
   assign trial   = {acc_ff, a_ff[PW-1]};
   assign sq_t    = b_ff + a_ff[W-1:0];

   always_comb begin
      acc_in = acc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      it_in  = it_ff;
      if (cmd.start) begin
         it_in = '0;
         case (cmd.op)
            OP_RDIV: begin
               acc_in = pcov_ff >> 1;
               a_in   = {pcov_ff[0], (PW-1)'(0)};
               b_in   = '0;
            end
            OP_TDIV: begin
               acc_in = '0;
               a_in   = {u_ff, (PW-U_W)'(0)};
               b_in   = '0;
            end
            OP_RSQ: begin
               acc_in = PW'({r2_ff, FRAC'(0)});
               a_in   = PW'(sq_bit);
               b_in   = '0;
            end
            OP_TSQ: begin
               acc_in = PW'(q_ff);
               a_in   = PW'(sq_bit);
               b_in   = '0;
            end
            default: begin
               acc_in = '0;
               a_in   = PW'(mul_a);
               b_in   = mul_b;
            end
         endcase
      end else if (cmd.run) begin
         it_in = it_ff + ITER_W'(1);
         case (cmd.op)
            OP_RDIV, OP_TDIV: begin
               a_in = a_ff << 1;
               if (trial >= {1'b0, divisor}) begin
                  acc_in = PW'(trial - {1'b0, divisor});
                  b_in   = {b_ff[W-2:0], 1'b1};
               end else begin
                  acc_in = trial[PW-1:0];
                  b_in   = {b_ff[W-2:0], 1'b0};
               end
            end
            OP_RSQ, OP_TSQ: begin
               a_in = a_ff >> 2;
               if (acc_ff[W-1:0] >= sq_t) begin
                  acc_in = PW'(acc_ff[W-1:0] - sq_t);
                  b_in   = (b_ff >> 1) + a_ff[W-1:0];
               end else begin
                  b_in   = b_ff >> 1;
               end
            end
            default: begin
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
            end
         endcase
      end
   end

   assign sts.last_iter = cmd.run && (it_ff == op_last(cmd.op));

   always_ff @(posedge clock) begin
      if (reset) begin
         it_ff <= '0;
      end else begin
         it_ff <= it_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   // intermediate results
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            OP_NSXX, OP_NSYY, OP_NSXY: tmp_ff <= acc_ff[W-1:0];
            OP_AXX:  sxx_ff  <= tmp_ff - acc_ff[W-1:0];
            OP_AYY:  syy_ff  <= tmp_ff - acc_ff[W-1:0];
            OP_SXSY: sxy_ff  <= tmp_ff - acc_ff[W-1:0];
            OP_PVAR: pvar_ff <= acc_ff;
            OP_PCOV: pcov_ff <= acc_ff;
            OP_RDIV: begin
               if (zvar) begin
                  r2_ff <= '0;
               end else if (b_ff > W'(R_ONE)) begin
                  r2_ff <= R_ONE;
               end else begin
                  r2_ff <= b_ff[R_W-1:0];
               end
            end
            OP_RSQ:  rm_ff <= b_ff[R_W-1:0];
            OP_UMUL: u_ff  <= acc_ff[U_W-1:0];
            OP_TDIV: q_ff  <= b_ff;
            OP_TSQ:  ts_ff <= b_ff[T_W:0];
            default: ;
         endcase
      end
   end

   // status and t selection
   always_comb begin
      if (few) begin
         st_val = ST_FEW;
         t_val  = T_SENTINEL;
      end else if (zvar) begin
         st_val = ST_ZVAR;
         t_val  = '0;
      end else if (r2_ff >= R_ONE) begin
         st_val = ST_PERFECT;
         t_val  = T_MAX;
      end else begin
         st_val = ST_OK;
         if ((R_W+T_SAT_SHIFT)'(u_ff) >= {dden, T_SAT_SHIFT'(0)}) begin
            t_val = T_MAX;
         end else if (ts_ff > (T_W+1)'(T_MAX)) begin
            t_val = T_MAX;
         end else begin
            t_val = ts_ff[T_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         r2_out_ff  <= r2_ff;
         rm_out_ff  <= rm_ff;
         neg_out_ff <= sxy_ff[W-1];
         t_out_ff   <= t_val;
         df_out_ff  <= df;
         st_out_ff  <= st_val;
      end
   end

   assign rsp_r_squared           = r2_out_ff;
   assign rsp_r_magnitude         = rm_out_ff;
   assign rsp_covariance_negative = neg_out_ff;
   assign rsp_t_statistic         = $signed(t_out_ff);
   assign rsp_degrees_of_freedom  = df_out_ff;
   assign rsp_status              = st_out_ff;

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[COUNT_BITS] |-> (cnt_ff[COUNT_BITS-1:0] == '0))
      else $error("pair count beyond limit");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (cnt_ff == '0 && sx_ff == '0 && sxp_ff == '0))
      else $error("sums not cleared");
   a_r2_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (r2_ff <= R_ONE))
      else $error("r squared out of range");
`endif

endmodule
